// File: sv/ea2r_pkg.sv
package ea2r_pkg;

  localparam int CORDIC_STEPS = 32;
  localparam int XY_BITS      = 36;
  localparam int Z_BITS       = 34;

  localparam logic signed [XY_BITS-1:0] CORDIC_GAIN  = 36'sd2608131496;
  localparam logic signed [Z_BITS-1:0]  QUARTER_TURN = 34'sd1073741824;
  localparam logic signed [Z_BITS-1:0]  HALF_TURN    = 34'sd2147483648;

  localparam logic [31:0] ATAN_STEPS [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  // one angle in flight through the rotation chain
  typedef struct packed {
    logic signed [XY_BITS-1:0] x;
    logic signed [XY_BITS-1:0] y;
    logic signed [Z_BITS-1:0]  z;
    logic                      flip;
  } ea2r_lane_t;

endpackage

// File: sv/ea2r_cordic_cell.sv
module ea2r_cordic_cell #(
  parameter int IDX = 0
) (
  input  logic                clk,
  input  ea2r_pkg::ea2r_lane_t lane_in,
  output ea2r_pkg::ea2r_lane_t lane_out
);

  localparam logic signed [ea2r_pkg::Z_BITS-1:0] ATAN =
    ea2r_pkg::Z_BITS'(ea2r_pkg::ATAN_STEPS[IDX]);

  ea2r_pkg::ea2r_lane_t lane_r, lane_nxt;
  logic signed [ea2r_pkg::XY_BITS-1:0] dx, dy;

  always_comb begin
    dx = lane_in.y >>> IDX;
    dy = lane_in.x >>> IDX;
    lane_nxt.flip = lane_in.flip;
    if (!lane_in.z[ea2r_pkg::Z_BITS-1]) begin
      lane_nxt.x = lane_in.x - dx;
      lane_nxt.y = lane_in.y + dy;
      lane_nxt.z = lane_in.z - ATAN;
    end else begin
      lane_nxt.x = lane_in.x + dx;
      lane_nxt.y = lane_in.y - dy;
      lane_nxt.z = lane_in.z + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    lane_r <= lane_nxt;
  end

  assign lane_out = lane_r;

endmodule

// File: sv/ea2r_matrix.sv
module ea2r_matrix #(
  parameter int FRACTION_BITS = 15
) (
  input  logic                          clk,
  input  ea2r_pkg::ea2r_lane_t          lane_a,
  input  ea2r_pkg::ea2r_lane_t          lane_b,
  input  ea2r_pkg::ea2r_lane_t          lane_c,
  output logic signed [FRACTION_BITS+1:0] r00,
  output logic signed [FRACTION_BITS+1:0] r10,
  output logic signed [FRACTION_BITS+1:0] r20,
  output logic signed [FRACTION_BITS+1:0] r01,
  output logic signed [FRACTION_BITS+1:0] r11,
  output logic signed [FRACTION_BITS+1:0] r21,
  output logic signed [FRACTION_BITS+1:0] r02,
  output logic signed [FRACTION_BITS+1:0] r12,
  output logic signed [FRACTION_BITS+1:0] r22
);

  localparam int F  = FRACTION_BITS;
  localparam int W  = F + 2;
  localparam int P  = 2 * W;
  localparam int XB = ea2r_pkg::XY_BITS;
  localparam logic signed [W+1:0]  ONE_S   = (W+2)'(1) <<< F;
  localparam logic signed [XB-1:0] ONE_X   = XB'(1) <<< F;
  localparam logic signed [XB-1:0] HALF_X  = XB'(1) <<< (31 - F);
  localparam logic signed [P-1:0]  HALF_P  = P'(1) <<< (F - 1);

  function automatic logic signed [W-1:0] clamp_sum(input logic signed [W+1:0] v);
    logic signed [W+1:0] t;
    t = v;
    if (v > ONE_S) t = ONE_S;
    else if (v < -ONE_S) t = -ONE_S;
    return t[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] to_q(input logic signed [XB-1:0] v,
                                               input logic neg);
    logic signed [XB-1:0] t;
    t = neg ? -v : v;
    t = (t + HALF_X) >>> (32 - F);
    if (t > ONE_X) t = ONE_X;
    else if (t < -ONE_X) t = -ONE_X;
    return t[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] mulq(input logic signed [W-1:0] a,
                                               input logic signed [W-1:0] b);
    logic signed [P-1:0] p;
    p = P'(a) * P'(b) + HALF_P;
    return p[F+W-1:F];
  endfunction

  // stage 0: rounded sines and cosines
  logic signed [W-1:0] sa_r, ca_r, sb_r, cb_r, sc_r, cc_r;
  always_ff @(posedge clk) begin
    sa_r <= to_q(lane_a.y, lane_a.flip);
    ca_r <= to_q(lane_a.x, lane_a.flip);
    sb_r <= to_q(lane_b.y, lane_b.flip);
    cb_r <= to_q(lane_b.x, lane_b.flip);
    sc_r <= to_q(lane_c.y, lane_c.flip);
    cc_r <= to_q(lane_c.x, lane_c.flip);
  end

  // stage 1: pair products
  logic signed [W-1:0] casb_r, sasb_r, cacb_r, sacb_r, nsb_r, cbsc_r, cbcc_r;
  logic signed [W-1:0] sacc_r, cacc_r, sasc_r, casc_r, sc1_r, cc1_r;
  always_ff @(posedge clk) begin
    casb_r <= mulq(ca_r, sb_r);
    sasb_r <= mulq(sa_r, sb_r);
    cacb_r <= mulq(ca_r, cb_r);
    sacb_r <= mulq(sa_r, cb_r);
    nsb_r  <= clamp_sum(-(W+2)'(sb_r));
    cbsc_r <= mulq(cb_r, sc_r);
    cbcc_r <= mulq(cb_r, cc_r);
    sacc_r <= mulq(sa_r, cc_r);
    cacc_r <= mulq(ca_r, cc_r);
    sasc_r <= mulq(sa_r, sc_r);
    casc_r <= mulq(ca_r, sc_r);
    sc1_r  <= sc_r;
    cc1_r  <= cc_r;
  end

  // stage 2: triple products, pair terms carried along
  logic signed [W-1:0] t01_r, t11_r, t02_r, t12_r;
  logic signed [W-1:0] sacc2_r, cacc2_r, sasc2_r, casc2_r;
  logic signed [W-1:0] r00_d, r10_d, r20_d, r21_d, r22_d;
  always_ff @(posedge clk) begin
    t01_r   <= mulq(casb_r, sc1_r);
    t11_r   <= mulq(sasb_r, sc1_r);
    t02_r   <= mulq(casb_r, cc1_r);
    t12_r   <= mulq(sasb_r, cc1_r);
    sacc2_r <= sacc_r;
    cacc2_r <= cacc_r;
    sasc2_r <= sasc_r;
    casc2_r <= casc_r;
    r00_d   <= clamp_sum((W+2)'(cacb_r));
    r10_d   <= clamp_sum((W+2)'(sacb_r));
    r20_d   <= nsb_r;
    r21_d   <= clamp_sum((W+2)'(cbsc_r));
    r22_d   <= clamp_sum((W+2)'(cbcc_r));
  end

  // stage 3: sums and saturation into the result register
  logic signed [W-1:0] r00_r, r10_r, r20_r, r01_r, r11_r, r21_r, r02_r, r12_r, r22_r;
  always_ff @(posedge clk) begin
    r00_r <= r00_d;
    r10_r <= r10_d;
    r20_r <= r20_d;
    r21_r <= r21_d;
    r22_r <= r22_d;
    r01_r <= clamp_sum((W+2)'(t01_r) - (W+2)'(sacc2_r));
    r11_r <= clamp_sum((W+2)'(t11_r) + (W+2)'(cacc2_r));
    r02_r <= clamp_sum((W+2)'(t02_r) + (W+2)'(sasc2_r));
    r12_r <= clamp_sum((W+2)'(t12_r) - (W+2)'(casc2_r));
  end

  assign r00 = r00_r;
  assign r10 = r10_r;
  assign r20 = r20_r;
  assign r01 = r01_r;
  assign r11 = r11_r;
  assign r21 = r21_r;
  assign r02 = r02_r;
  assign r12 = r12_r;
  assign r22 = r22_r;

endmodule

// File: sv/euler_angles_to_rotation_matrix.sv
// pipeline: from the accepting edge to the out_valid strobe, each beat passes through
//   32 cordic cells, rounding, two product stages, sum and saturation
// throughput: one beat per cycle, busy is never raised
// reset: synchronous active-low rst_n clears the valid pipeline only
// results appear for one cycle on out_valid and cannot be held off
module euler_angles_to_rotation_matrix #(
  parameter int ANGLE_BITS    = 16,
  parameter int FRACTION_BITS = 15
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [ANGLE_BITS-1:0]  in_yaw_angle,
  input  logic signed [ANGLE_BITS-1:0]  in_pitch_angle,
  input  logic signed [ANGLE_BITS-1:0]  in_roll_angle,
  output logic                          out_valid,
  output logic signed [FRACTION_BITS+1:0] out_r00,
  output logic signed [FRACTION_BITS+1:0] out_r10,
  output logic signed [FRACTION_BITS+1:0] out_r20,
  output logic signed [FRACTION_BITS+1:0] out_r01,
  output logic signed [FRACTION_BITS+1:0] out_r11,
  output logic signed [FRACTION_BITS+1:0] out_r21,
  output logic signed [FRACTION_BITS+1:0] out_r02,
  output logic signed [FRACTION_BITS+1:0] out_r12,
  output logic signed [FRACTION_BITS+1:0] out_r22
);

  localparam int N   = ea2r_pkg::CORDIC_STEPS;
  localparam int LAT = N + 4;

  function automatic ea2r_pkg::ea2r_lane_t widen(input logic [ANGLE_BITS-1:0] ang);
    logic [31:0] u;
    logic signed [ea2r_pkg::Z_BITS-1:0] z;
    ea2r_pkg::ea2r_lane_t l;
    u = 32'(ang) << (32 - ANGLE_BITS);
    z = ea2r_pkg::Z_BITS'($signed(u));
    l.flip = 1'b0;
    // fold into the right half-plane, negate at the end
    if (z > ea2r_pkg::QUARTER_TURN || z < -ea2r_pkg::QUARTER_TURN) begin
      l.flip = 1'b1;
      z = z[ea2r_pkg::Z_BITS-1] ? z + ea2r_pkg::HALF_TURN : z - ea2r_pkg::HALF_TURN;
    end
    l.z = z;
    l.x = ea2r_pkg::CORDIC_GAIN;
    l.y = '0;
    return l;
  endfunction

  ea2r_pkg::ea2r_lane_t lane_a [N+1];
  ea2r_pkg::ea2r_lane_t lane_b [N+1];
  ea2r_pkg::ea2r_lane_t lane_c [N+1];

  assign lane_a[0] = widen(in_yaw_angle);
  assign lane_b[0] = widen(in_pitch_angle);
  assign lane_c[0] = widen(in_roll_angle);

  for (genvar i = 0; i < N; i++) begin : g_cell
    ea2r_cordic_cell #(.IDX(i)) u_cell_a (.clk(clk), .lane_in(lane_a[i]), .lane_out(lane_a[i+1]));
    ea2r_cordic_cell #(.IDX(i)) u_cell_b (.clk(clk), .lane_in(lane_b[i]), .lane_out(lane_b[i+1]));
    ea2r_cordic_cell #(.IDX(i)) u_cell_c (.clk(clk), .lane_in(lane_c[i]), .lane_out(lane_c[i+1]));
  end

  ea2r_matrix #(.FRACTION_BITS(FRACTION_BITS)) u_matrix (
    .clk(clk), .lane_a(lane_a[N]), .lane_b(lane_b[N]), .lane_c(lane_c[N]),
    .r00(out_r00), .r10(out_r10), .r20(out_r20),
    .r01(out_r01), .r11(out_r11), .r21(out_r21),
    .r02(out_r02), .r12(out_r12), .r22(out_r22)
  );

  logic [LAT-1:0] vld_r, vld_nxt;
  assign vld_nxt = {vld_r[LAT-2:0], start};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign busy      = 1'b0;
  assign out_valid = vld_r[LAT-1];

endmodule

// File: sv/ea2r_checker.sv
module ea2r_checker #(
  parameter int FRACTION_BITS = 15
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          out_valid,
  input logic signed [FRACTION_BITS+1:0] out_r00,
  input logic signed [FRACTION_BITS+1:0] out_r20,
  input logic signed [FRACTION_BITS+1:0] out_r11
);

  localparam logic signed [FRACTION_BITS+1:0] ONE = (FRACTION_BITS+2)'(1) <<< FRACTION_BITS;

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##36 out_valid)
    else $error("beat accepted but no result after 36 cycles");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, 36))
    else $error("result without an accepted beat");

  a_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_r00 <= ONE && out_r00 >= -ONE && out_r20 <= ONE &&
                   out_r20 >= -ONE && out_r11 <= ONE && out_r11 >= -ONE))
    else $error("matrix entry out of range");

endmodule

bind euler_angles_to_rotation_matrix ea2r_checker #(.FRACTION_BITS(FRACTION_BITS)) u_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid),
  .out_r00(out_r00), .out_r20(out_r20), .out_r11(out_r11)
);
